/* rtl/core/fswp_pkg.sv */
// ----------------------------------------------------------------------------
// fswp_pkg
// shared types and constants for the flash stream word packer
// ----------------------------------------------------------------------------
package fswp_pkg;

	// default geometry of the flash part
	localparam int SECTOR_BYTES_DEF = 4096;
	localparam int ADDRESS_BITS_DEF = 24;

	// fixed field widths
	localparam int DATA_W      = 8;
	localparam int START_W     = 24;
	localparam int SECTOR_NUM_W = 12;
	localparam int WORD_ADDR_W = 24;
	localparam int WORD_W      = 32;

	// result queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// flash command codes
	typedef enum logic {
		OP_ERASE = 1'b0,
		OP_WRITE = 1'b1
	} flash_op_t;

	// one flash command as stored in the result queue
	typedef struct packed {
		flash_op_t                 flash_op;
		logic [SECTOR_NUM_W-1:0]   sector_number;
		logic [WORD_ADDR_W-1:0]    word_address;
		logic [WORD_W-1:0]         word_data;
		logic                      last_of_run;
	} result_t;

endpackage

/* rtl/core/fswp_if.sv */
// ----------------------------------------------------------------------------
// fswp channel interfaces
// valid/ready channels for stream bytes, flash commands and configuration
// ----------------------------------------------------------------------------

// image byte stream
interface fswp_byte_if;
	logic                           valid;
	logic                           ready;
	logic [fswp_pkg::DATA_W-1:0]    data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// flash command stream
interface fswp_op_if;
	logic                               valid;
	logic                               ready;
	fswp_pkg::flash_op_t                flash_op;
	logic [fswp_pkg::SECTOR_NUM_W-1:0]  sector_number;
	logic [fswp_pkg::WORD_ADDR_W-1:0]   word_address;
	logic [fswp_pkg::WORD_W-1:0]        word_data;
	logic                               last_of_run;

	modport source (output valid, output flash_op, output sector_number,
		output word_address, output word_data, output last_of_run, input ready);
	modport sink   (input valid, input flash_op, input sector_number,
		input word_address, input word_data, input last_of_run, output ready);
endinterface

// start address register write channel
interface fswp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fswp_pkg::START_W-1:0]   start_address;

	modport source (output valid, output start_address, input ready);
	modport sink   (input valid, input start_address, output ready);
endinterface

/* rtl/core/flash_stream_word_packer_core.sv */
// ----------------------------------------------------------------------------
// flash_stream_word_packer_core
// packs image bytes into 32-bit flash words and issues the sector erases
// ----------------------------------------------------------------------------
// Usage:
//   bytes : image byte stream, one byte per transaction, in stream order.
//   ops   : flash commands; erase (sector_number) or write (word_address,
//           word_data, first stream byte in bits 7:0). last_of_run marks the
//           final command caused by one byte.
//   cfg   : writes start_address; restarts packing and erase tracking. It is
//           always ready and must only be written while the block is idle.
// A byte that completes a word yields an optional erase of the next sector
// followed by the word write; other bytes are only held. A trailing partial
// word is never flushed.
// Throughput: one byte per cycle while the queue has room. The commands of a
// word are written into the queue when its fourth byte is taken; an erase is
// always followed by its write. Commands pass through a four-entry queue; bytes are
// refused while fewer than two entries are free, so a stalled receiver
// backs the byte stream up after at most three words.
// Reset: start address 0, no bytes held, queue empty, next erase sector 0.
// ----------------------------------------------------------------------------
module flash_stream_word_packer_core #(
	parameter int SECTOR_BYTES = fswp_pkg::SECTOR_BYTES_DEF,
	parameter int ADDRESS_BITS = fswp_pkg::ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fswp_cfg_if.sink    cfg,
	fswp_byte_if.sink   bytes,
	fswp_op_if.source   ops
);

	// sector size is a power of two; sector index is a plain shift
	localparam int SECTOR_LOG = $clog2(SECTOR_BYTES);
	localparam int SECT_W     = ADDRESS_BITS - SECTOR_LOG;
	localparam int NES_W      = SECT_W + 1;
	localparam int START_W    = fswp_pkg::START_W;
	localparam int OUT_AW     = fswp_pkg::WORD_ADDR_W;
	localparam int SNUM_W     = fswp_pkg::SECTOR_NUM_W;
	localparam int PTR_W      = fswp_pkg::QUEUE_PTR_W;
	localparam int CNT_W      = fswp_pkg::QUEUE_CNT_W;
	localparam int DEPTH      = fswp_pkg::QUEUE_DEPTH;

	// packing state
	logic [23:0]               pend_bytes_q;
	logic [1:0]                pend_cnt_q;
	logic [ADDRESS_BITS-1:0]   wr_addr_q;
	logic [NES_W-1:0]          nes_q;

	// result queue
	fswp_pkg::result_t         queue_q [DEPTH];
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [CNT_W-1:0]          cnt_q;

	logic                      byte_acc;
	logic                      op_acc;
	logic                      word_done;
	logic [ADDRESS_BITS-1:0]   start_a;
	logic [ADDRESS_BITS+START_W-1:0] start_ext;
	logic [ADDRESS_BITS-1:0]   last_addr;
	logic [NES_W-1:0]          last_sect;
	logic                      need_erase;
	logic [NES_W+SNUM_W-1:0]   nes_ext;
	logic [ADDRESS_BITS+OUT_AW-1:0] wa_ext;
	fswp_pkg::result_t         erase_res;
	fswp_pkg::result_t         write_res;
	logic [1:0]                push_n;
	fswp_pkg::result_t         head;

	// handshakes
	assign cfg.ready   = 1'b1;
	assign bytes.ready = (cnt_q <= CNT_W'(DEPTH - 2));
	assign byte_acc    = bytes.valid & bytes.ready;
	assign op_acc      = ops.valid & ops.ready;
	assign word_done   = byte_acc & (pend_cnt_q == 2'd3);

	// start address reduced to the flash address width
	assign start_ext = {{ADDRESS_BITS{1'b0}}, cfg.start_address};
	assign start_a   = start_ext[ADDRESS_BITS-1:0];

	// sector of the word's last byte against the next sector to erase
	assign last_addr  = wr_addr_q + ADDRESS_BITS'(3);
	assign last_sect  = {1'b0, last_addr[ADDRESS_BITS-1:SECTOR_LOG]};
	assign need_erase = (last_sect >= nes_q);

	// command words
	assign nes_ext = {{SNUM_W{1'b0}}, nes_q};
	assign wa_ext  = {{OUT_AW{1'b0}}, wr_addr_q};

	always_comb begin
		erase_res               = '0;
		erase_res.flash_op      = fswp_pkg::OP_ERASE;
		erase_res.sector_number = nes_ext[SNUM_W-1:0];
		erase_res.last_of_run   = 1'b0;

		write_res               = '0;
		write_res.flash_op      = fswp_pkg::OP_WRITE;
		write_res.word_address  = wa_ext[OUT_AW-1:0];
		write_res.word_data     = {bytes.data_byte, pend_bytes_q};
		write_res.last_of_run   = 1'b1;
	end

	assign push_n = word_done ? (need_erase ? 2'd2 : 2'd1) : 2'd0;

	// packing and erase tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			wr_addr_q  <= '0;
			nes_q      <= '0;
		end else if (cfg.valid) begin
			pend_cnt_q <= '0;
			wr_addr_q  <= start_a;
			nes_q      <= {1'b0, start_a[ADDRESS_BITS-1:SECTOR_LOG]};
		end else if (byte_acc) begin
			pend_cnt_q <= pend_cnt_q + 2'd1;
			if (word_done) begin
				wr_addr_q <= wr_addr_q + ADDRESS_BITS'(4);
				if (need_erase) begin
					nes_q <= nes_q + NES_W'(1);
				end
			end
		end
	end

	// held bytes, no reset needed
	always_ff @(posedge clk) begin
		if (byte_acc && !word_done) begin
			pend_bytes_q[8*pend_cnt_q +: 8] <= bytes.data_byte;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (word_done) begin
			if (need_erase) begin
				queue_q[wr_ptr_q]         <= erase_res;
				queue_q[wr_ptr_q + 2'd1]  <= write_res;
			end else begin
				queue_q[wr_ptr_q]         <= write_res;
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (op_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(op_acc);
		end
	end

	// output side
	assign head              = queue_q[rd_ptr_q];
	assign ops.valid         = (cnt_q != '0);
	assign ops.flash_op      = head.flash_op;
	assign ops.sector_number = head.sector_number;
	assign ops.word_address  = head.word_address;
	assign ops.word_data     = head.word_data;
	assign ops.last_of_run   = head.last_of_run;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overfilled");

	a_no_push_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_acc && pend_cnt_q != 2'd3) |=> (cnt_q <= $past(cnt_q)))
		else $error("partial word produced a command");

	a_erase_has_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ops.valid && head.flash_op == fswp_pkg::OP_ERASE) |-> (cnt_q >= CNT_W'(2)))
		else $error("erase queued without its write");

	a_nes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nes_q <= {1'b1, {SECT_W{1'b0}}})
		else $error("erase tracking ran past the top of flash");

	a_word_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(word_done && !cfg.valid) |=> (pend_cnt_q == 2'd0))
		else $error("packer did not restart after a full word");

endmodule
